>>> rtl/srd_pkg.sv
// Shared types and character constants for the serial response deframer.
package srd_pkg;

  localparam logic [7:0] CHAR_START = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;  // 'A' - 10

  localparam int unsigned PAYLOAD_OFS  = 6;
  localparam int unsigned RESULT_LIMIT = 64;
  localparam logic [6:0]  MAX_PAYLOAD_RST = 7'd64;

  typedef enum logic [1:0] {
    STATUS_DATA  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_OTHER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_RX,
    S_ONE,
    S_RD,
    S_WR
  } state_e;

  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    hex_digit = (c >= CHAR_A) ? c - HEX_ALPHA_OFS : c - CHAR_ZERO;
  endfunction

endpackage

>>> rtl/srd_in_if.sv
// Received byte channel.
interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/srd_out_if.sv
// Result channel: payload byte, declared length, status and last flag.
interface srd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] declared_length;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output payload_byte, output declared_length,
                  output status, output last, input ready);
  modport sink   (input valid, input payload_byte, input declared_length,
                  input status, input last, output ready);
endinterface

>>> rtl/serial_response_deframer_core.sv
// Serial response deframer: collects '*'...CR LF frames and delivers the payload.
//
// rx_i takes one received character per beat. Outside a frame every byte but
// '*' is dropped. Frame bytes go into a BUFFER_BYTES-deep RAM; bytes beyond it
// are counted but not stored. An LF right after a CR closes the frame.
// res_o then carries one beat per payload byte (status data, last on the final
// one), or a single empty-frame or other-response beat.
// Throughput: one byte per cycle while a frame is being received. After the
// closing beat, a status-only result is loaded in S_ONE, or each payload byte
// is read from the RAM in S_RD, then loaded into the output register in S_WR;
// rx_i is held off meanwhile. A result sits in an output register, so rx_i
// accepts the next byte while the last result of a frame still waits. When
// res_o stalls, payload readout waits with it; nothing is lost.
// cfg_we_i writes max_payload (reset 64; above 64 acts as 64). Write it only
// while idle. Reset returns to hunting for '*'; the RAM needs no clearing.
module serial_response_deframer_core #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  srd_in_if.sink            rx_i,
  srd_out_if.source         res_o
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam logic [7:0]  BUF_LEN = 8'(BUFFER_BYTES);

  srd_pkg::state_e  state_q, state_d;
  srd_pkg::status_e kind_q;

  logic [6:0] max_payload_q;
  logic       in_frame_q;
  logic [7:0] byte_count_q;
  logic [7:0] prev_q;
  logic [7:0] hdr1_q, hdr2_q, hdr4_q, hdr5_q;
  logic [7:0] len_q;
  logic [6:0] cnt_q;
  logic [6:0] k_q;

  logic       res_valid_q;
  logic [7:0] res_byte_q, res_len_q;
  logic [1:0] res_status_q;
  logic       res_last_q;

  // handshake and control
  logic rx_fire, closing, keep, start;
  logic slot_free, load_one, load_data, ram_re, ram_we, k_last;
  logic [7:0] rx_b;

  // frame close decode
  logic [7:0] bc_m1, end_w, avail;
  logic [7:0] c1, c2, c4, c5, d0, d1, len_w;
  logic [6:0] limit, cnt_w;
  logic       is_dr;
  logic [7:0] rd_idx;
  logic [7:0] rdata;

  assign rx_b      = rx_i.rx_byte;
  assign rx_fire   = rx_i.valid && rx_i.ready;
  assign closing   = in_frame_q && (rx_b == srd_pkg::CHAR_LF) && (prev_q == srd_pkg::CHAR_CR);
  assign start     = !in_frame_q && (rx_b == srd_pkg::CHAR_START);
  assign keep      = rx_fire && (start || (in_frame_q && !closing));
  assign slot_free = !res_valid_q || res_o.ready;
  assign k_last    = (k_q + 7'd1) == cnt_q;

  // content ends before the closing CR, clipped to the store
  always_comb begin
    bc_m1 = byte_count_q - 8'd1;
    end_w = (bc_m1 > BUF_LEN) ? BUF_LEN : bc_m1;
    avail = (end_w > 8'(srd_pkg::PAYLOAD_OFS)) ? end_w - 8'(srd_pkg::PAYLOAD_OFS) : 8'd0;
    c1 = (end_w > 8'd1) ? hdr1_q : 8'd0;
    c2 = (end_w > 8'd2) ? hdr2_q : 8'd0;
    c4 = (end_w > 8'd4) ? hdr4_q : srd_pkg::CHAR_ZERO;
    c5 = (end_w > 8'd5) ? hdr5_q : srd_pkg::CHAR_ZERO;
    is_dr = (c1 == srd_pkg::CHAR_D) && (c2 == srd_pkg::CHAR_R);
    d0 = srd_pkg::hex_digit(c4);
    d1 = srd_pkg::hex_digit(c5);
    len_w = {d0[3:0], 4'd0} | d1;
    limit = (max_payload_q > 7'(srd_pkg::RESULT_LIMIT)) ? 7'(srd_pkg::RESULT_LIMIT)
                                                         : max_payload_q;
    cnt_w = (len_w < {1'b0, limit}) ? len_w[6:0] : limit;
    if ({1'b0, cnt_w} > avail) begin
      cnt_w = avail[6:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srd_pkg::S_RX: begin
        if (rx_fire && closing) begin
          state_d = (is_dr && cnt_w != 7'd0) ? srd_pkg::S_RD : srd_pkg::S_ONE;
        end
      end
      srd_pkg::S_ONE: begin
        if (slot_free) state_d = srd_pkg::S_RX;
      end
      srd_pkg::S_RD: state_d = srd_pkg::S_WR;
      srd_pkg::S_WR: begin
        if (slot_free) state_d = k_last ? srd_pkg::S_RX : srd_pkg::S_RD;
      end
      default: state_d = srd_pkg::S_RX;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rx_i.ready = 1'b0;
    load_one   = 1'b0;
    load_data  = 1'b0;
    ram_re     = 1'b0;
    unique case (state_q)
      srd_pkg::S_RX:  rx_i.ready = 1'b1;
      srd_pkg::S_ONE: load_one   = slot_free;
      srd_pkg::S_RD:  ram_re     = 1'b1;
      srd_pkg::S_WR:  load_data  = slot_free;
      default: ;
    endcase
  end

  // writes and reads never overlap: reads happen only outside S_RX
  assign ram_we = keep && ((start ? 8'd0 : byte_count_q) < BUF_LEN);
  assign rd_idx = 8'(srd_pkg::PAYLOAD_OFS) + {1'b0, k_q};

  srd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(start ? '0 : byte_count_q[ADDR_W-1:0]),
    .wdata_i(rx_b),
    .re_i   (ram_re),
    .raddr_i(rd_idx[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= srd_pkg::S_RX;
      max_payload_q <= srd_pkg::MAX_PAYLOAD_RST;
      in_frame_q    <= 1'b0;
      byte_count_q  <= 8'd0;
      prev_q        <= 8'd0;
      res_valid_q   <= 1'b0;
      k_q           <= 7'd0;
      kind_q        <= srd_pkg::STATUS_OTHER;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_payload_q <= cfg_wdata_i;
      if (keep) begin
        in_frame_q   <= 1'b1;
        byte_count_q <= start ? 8'd1
                      : (byte_count_q == 8'hFF) ? byte_count_q : byte_count_q + 8'd1;
        prev_q       <= rx_b;
      end
      if (rx_fire && closing) begin
        in_frame_q <= 1'b0;
        k_q        <= 7'd0;
        kind_q     <= !is_dr ? srd_pkg::STATUS_OTHER
                    : (cnt_w == 7'd0) ? srd_pkg::STATUS_EMPTY : srd_pkg::STATUS_DATA;
      end
      if (load_data && !k_last) k_q <= k_q + 7'd1;
      if (load_one || load_data) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (keep && !start) begin
      if (byte_count_q == 8'd1) hdr1_q <= rx_b;
      if (byte_count_q == 8'd2) hdr2_q <= rx_b;
      if (byte_count_q == 8'd4) hdr4_q <= rx_b;
      if (byte_count_q == 8'd5) hdr5_q <= rx_b;
    end
    if (rx_fire && closing) begin
      len_q <= is_dr ? len_w : 8'd0;
      cnt_q <= cnt_w;
    end
    if (load_one) begin
      res_byte_q   <= 8'd0;
      res_len_q    <= len_q;
      res_status_q <= kind_q;
      res_last_q   <= 1'b1;
    end else if (load_data) begin
      res_byte_q   <= rdata;
      res_len_q    <= len_q;
      res_status_q <= srd_pkg::STATUS_DATA;
      res_last_q   <= k_last;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.payload_byte    = res_byte_q;
  assign res_o.declared_length = res_len_q;
  assign res_o.status          = res_status_q;
  assign res_o.last            = res_last_q;

endmodule

>>> rtl/srd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> tb/serial_response_deframer_core_test.sv
// Self-checking testbench for serial_response_deframer_core: directed and random frames vs a predictor.
module serial_response_deframer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srd_pkg::*;

  localparam int BUF_BYTES = 128;
  localparam int RAND_PER_PHASE = 12;
  localparam int N_SETTINGS = 4;
  // worst case is roughly 450 bytes, each behind a driver gap, plus every result
  // held by a sparse receiver ready pattern at each readout; several times that
  localparam int CYCLE_LIMIT = 60000;

  typedef struct {
    logic [7:0] payload;
    logic [7:0] dlen;
    status_e    status;
    logic       is_last;
  } beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;

  srd_in_if  rx_if ();
  srd_out_if res_if ();

  serial_response_deframer_core #(
    .BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame predictor
  logic       in_frame_q = 1'b0;
  logic [7:0] byte_cnt_q = '0;
  logic [7:0] last_byte_q = '0;
  logic [7:0] frame_mem [BUF_BYTES];
  logic [6:0] max_payload_q = MAX_PAYLOAD_RST;

  logic [7:0] rx_backlog [$];
  beat_t      beats_due [$];

  int frame_bytes_queued = 0;
  int frames_queued = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  function automatic logic [7:0] stored_or(input int unsigned idx, input int unsigned upto,
                                           input logic [7:0] fill);
    return (idx < upto) ? frame_mem[idx] : fill;
  endfunction

  task automatic keep_rx_byte(input logic [7:0] b);
    if (byte_cnt_q < BUF_BYTES) frame_mem[byte_cnt_q] = b;
    if (byte_cnt_q != 8'hFF) byte_cnt_q++;
    last_byte_q = b;
  endtask

  task automatic expect_beat(input logic [7:0] payload, input logic [7:0] dlen,
                             input status_e status, input logic is_last);
    beat_t e;
    e.payload = payload;
    e.dlen    = dlen;
    e.status  = status;
    e.is_last = is_last;
    beats_due.push_back(e);
  endtask

  task automatic track_rx_byte(input logic [7:0] b);
    int unsigned body_end, avail, cap, n_out;
    logic [7:0]  hi_d, lo_d, decl;
    if (!in_frame_q) begin
      if (b == CHAR_START) begin
        in_frame_q = 1'b1;
        byte_cnt_q = '0;
        keep_rx_byte(b);
      end
    end else if (b != CHAR_LF || last_byte_q != CHAR_CR) begin
      keep_rx_byte(b);
    end else begin
      in_frame_q = 1'b0;
      // content stops before the closing CR and at the end of the store
      body_end = (byte_cnt_q > 0) ? byte_cnt_q - 1 : 0;
      if (body_end > BUF_BYTES) body_end = BUF_BYTES;
      if (stored_or(1, body_end, 8'h00) != CHAR_D ||
          stored_or(2, body_end, 8'h00) != CHAR_R) begin
        expect_beat(8'h00, 8'h00, STATUS_OTHER, 1'b1);
      end else begin
        hi_d = stored_or(4, body_end, CHAR_ZERO);
        lo_d = stored_or(5, body_end, CHAR_ZERO);
        hi_d = hi_d - ((hi_d >= CHAR_A) ? HEX_ALPHA_OFS : CHAR_ZERO);
        lo_d = lo_d - ((lo_d >= CHAR_A) ? HEX_ALPHA_OFS : CHAR_ZERO);
        decl = {hi_d[3:0], 4'h0} | lo_d;
        avail = (body_end > PAYLOAD_OFS) ? body_end - PAYLOAD_OFS : 0;
        cap = (max_payload_q > RESULT_LIMIT) ? RESULT_LIMIT : max_payload_q;
        n_out = decl;
        if (n_out > cap) n_out = cap;
        if (n_out > avail) n_out = avail;
        if (n_out == 0) begin
          expect_beat(8'h00, decl, STATUS_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < n_out; k++)
            expect_beat(frame_mem[PAYLOAD_OFS + k], decl, STATUS_DATA, k == n_out - 1);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0d] mismatch: %s", cycle_cnt, what);
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) track_rx_byte(rx_if.rx_byte);
      if (!rx_if.valid || rx_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_if.valid <= 1'b0;
        end else if (rx_backlog.size() > 0) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= rx_backlog.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor; ready follows a rotating pattern that is reloaded now and then
  logic [7:0] ready_pat = 8'hFF;
  int         pat_left = 0;

  always @(posedge clk_i) begin : res_check
    beat_t want;
    int    pick;
    if (rst_ni && res_if.valid && res_if.ready) begin
      beats_checked++;
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (payload %02h status %0d)",
                                  res_if.payload_byte, res_if.status));
      end else begin
        want = beats_due.pop_front();
        if (res_if.payload_byte !== want.payload)
          report_mismatch($sformatf("payload_byte %02h, want %02h",
                                    res_if.payload_byte, want.payload));
        if (res_if.declared_length !== want.dlen)
          report_mismatch($sformatf("declared_length %02h, want %02h",
                                    res_if.declared_length, want.dlen));
        if (res_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", res_if.status, want.status));
        if (res_if.last !== want.is_last)
          report_mismatch($sformatf("last %b, want %b", res_if.last, want.is_last));
      end
    end
    if (pat_left == 0) begin
      pick = $urandom_range(0, 2);
      case (pick)
        0: ready_pat = 8'hFF;
        1: ready_pat = 8'($urandom_range(1, 255));
        default: ready_pat = 8'h01 << $urandom_range(0, 7);
      endcase
      pat_left = $urandom_range(8, 64);
    end else begin
      pat_left--;
    end
    res_if.ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[7:1]};
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycle_cnt, beats_due.size());
      $display("serial_response_deframer_core_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_A + 8'(n - 4'd10);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    frame_bytes_queued++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_close();
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
    frames_queued++;
  endtask

  // random bytes that never form CR LF, so the frame runs to its intended end
  task automatic put_body(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF && rx_backlog.size() > 0 && rx_backlog[$] == CHAR_CR) b = 8'h7E;
      put_byte(b);
    end
  endtask

  task automatic fill_random(input int budget);
    int start, pick, decl, n;
    start = frame_bytes_queued;
    while (frame_bytes_queued - start < budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        decl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        if ($urandom_range(0, 5) == 0) n = $urandom_range(0, 4);
        else if (decl > 16) n = $urandom_range(0, 16);
        else n = decl + $urandom_range(0, 3);
        put_text("*DR");
        put_body(1);
        if (pick == 13) begin
          put_body(2);
        end else begin
          put_byte(hex_char(decl[7:4]));
          put_byte(hex_char(decl[3:0]));
        end
        put_body(n);
        put_close();
      end else if (pick < 17) begin
        put_byte(CHAR_START);
        put_body($urandom_range(0, 8));
        put_close();
      end else if (pick < 19) begin
        // line noise between frames
        repeat ($urandom_range(1, 6)) rx_backlog.push_back(8'($urandom_range(0, 255)));
      end else begin
        // frame cut off; the next frame's bytes land in it
        put_byte(CHAR_START);
        put_body($urandom_range(0, 10));
      end
    end
  endtask

  task automatic set_max_payload(input logic [6:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_payload_q = v;
  endtask

  task automatic drain();
    while (rx_backlog.size() != 0 || rx_if.valid || beats_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  logic [6:0] cap_plan [N_SETTINGS];

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    cap_plan = '{7'd1, 7'd0, 7'd127, 7'd2};
    cap_plan[3] = 7'($urandom_range(2, 12));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames at the reset value of max_payload
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'hFF);
    rx_backlog.push_back(CHAR_CR);
    rx_backlog.push_back(CHAR_LF);
    put_text("*DR,05");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CHAR_START);
    put_byte(CHAR_LF);
    put_byte(8'h80);
    put_close();
    put_text("*DR,00xyz");
    put_close();
    put_text("*OK");
    put_close();
    put_text("*DX,05abcde");
    put_close();
    put_text("*D");
    put_close();
    put_byte(CHAR_START);
    put_close();
    put_text("*DR");
    put_close();
    put_text("*DR,4");
    put_close();
    put_text("*DR,02");
    put_byte(CHAR_CR);
    put_text("ab");
    put_close();
    put_text("*DR,ff");
    put_body(3);
    put_close();
    put_text("*DR,z~q");
    put_close();
    put_text("*DR,01X");
    put_byte(CHAR_CR);
    put_close();
    // runs past the end of the store and past the payload limit
    put_text("*DR,FF");
    put_body(124);
    put_close();
    drain();

    for (int p = 0; p < N_SETTINGS; p++) begin
      set_max_payload(cap_plan[p]);
      put_text("*DR,FF");
      put_body(((cap_plan[p] > 7'd64) ? 64 : int'(cap_plan[p])) + 2);
      put_close();
      fill_random(RAND_PER_PHASE);
      drain();
    end

    $display("Ran %0d frames (%0d frame bytes) under %0d max_payload values incl. 0, 1, 64, 127",
             frames_queued, frame_bytes_queued, N_SETTINGS + 1);
    $display("Checked %0d result beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("serial_response_deframer_core_test: PASS");
    end else begin
      $display("serial_response_deframer_core_test: FAIL");
    end
    $finish;
  end

endmodule
